// ----- design/npfc_pkg.sv -----
// Shared types and constants for the nearest-point-to-frame-corners block.
// Used by every module of the block and by its checker; depends on nothing.
package npfc_pkg;

    // Field widths
    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = 12;
    localparam int BOUND_BITS  = 25;
    localparam int MAG_BITS    = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int DIST_BITS   = SQ_BITS + 1;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_PTS     = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = BOUND_BITS;

    // Corner numbering, also the bit order of corners_found
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BR = 2;
    localparam int CORNER_BL = 3;

    // Register reset values
    localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(480);
    localparam logic [BOUND_BITS-1:0] BOUND_RESET  = BOUND_BITS'(100000);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_INITIAL_BOUND = 2'd2
    } t_cfg_idx;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [DIST_BITS-1:0]  t_dist;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_point;

    // Input word: one segment
    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        logic   last_segment;
    } t_in_word;

    // Output word: one frame summary
    typedef struct packed {
        t_coord top_left_x;
        t_coord top_left_y;
        t_coord top_right_x;
        t_coord top_right_y;
        t_coord bottom_right_x;
        t_coord bottom_right_y;
        t_coord bottom_left_x;
        t_coord bottom_left_y;
        logic [NUM_CORNERS-1:0] corners_found;
    } t_out_word;

    // Distance stage to best-tracking stage
    typedef struct packed {
        t_dist  [NUM_PTS-1:0][NUM_CORNERS-1:0] sq_dist;
        t_point [NUM_PTS-1:0]                  pt;
        logic                                  last;
    } t_dist_word;

endpackage

// ----- design/nearest_point_to_frame_corners.sv -----
// Top level of the nearest-point-to-frame-corners block: config registers and stages.
// Depends on npfc_pkg, npfc_dist and npfc_best.
//
// Takes one segment word per cycle unless stalled and tracks, for each frame
// corner, the endpoint with the smallest squared distance below initial_bound.
// A segment flagged last_segment is folded in first, then one output word is
// emitted and the tracking restarts for the next frame. An accepted segment
// passes the input register, the distance register (eight 12x12 squares and
// adds), then the best-update compare that writes the output register.
// Throughput is one segment per clock while nothing stalls, set by the
// compare-and-update loop on the corner bests; an output word held by stall
// lets the pipeline keep filling until the final segment of the next frame
// needs the output register. Configuration is written through a plain write
// port, by the user only while no segment is in flight (not enforced).
module nearest_point_to_frame_corners (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  npfc_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output npfc_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [npfc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [npfc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import npfc_pkg::*;

    logic [DIM_BITS-1:0]   r_width;
    logic [DIM_BITS-1:0]   r_height;
    logic [BOUND_BITS-1:0] r_bound;
    logic                  d_valid;
    logic                  d_take;
    t_dist_word            d_word;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_bound  <= BOUND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[DIM_BITS-1:0];
                CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[DIM_BITS-1:0];
                CFG_INITIAL_BOUND: r_bound  <= i_cfg_data[BOUND_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Distance stage
    npfc_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_word   (i_in_word),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (d_valid),
        .i_take   (d_take),
        .o_word   (d_word)
    );

    // Best tracking and output
    npfc_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_take  (d_take),
        .i_word  (d_word),
        .i_bound (r_bound),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

// ----- design/npfc_dist.sv -----
// Input register and squared-distance stage: eight corner distances per segment.
// Depends on npfc_pkg.
module npfc_dist (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  npfc_pkg::t_in_word           i_word,
    input  logic [npfc_pkg::DIM_BITS-1:0] i_width,
    input  logic [npfc_pkg::DIM_BITS-1:0] i_height,
    output logic                         o_valid,
    input  logic                         i_take,
    output npfc_pkg::t_dist_word         o_word
);
    import npfc_pkg::*;

    logic       r_a_valid;
    t_in_word   r_a;
    logic       r_d_valid;
    t_dist_word r_d;
    t_dist_word n_d;
    logic       a_en;
    logic       d_en;
    t_point     pts [NUM_PTS];
    logic [SQ_BITS-1:0] sq_xl [NUM_PTS];
    logic [SQ_BITS-1:0] sq_xr [NUM_PTS];
    logic [SQ_BITS-1:0] sq_yt [NUM_PTS];
    logic [SQ_BITS-1:0] sq_yb [NUM_PTS];

    // Square of |a - b|
    function automatic logic [SQ_BITS-1:0] f_sq_diff(logic [MAG_BITS-1:0] a,
                                                      logic [MAG_BITS-1:0] b);
        logic [MAG_BITS-1:0] m;
        m = (a >= b) ? (a - b) : (b - a);
        return SQ_BITS'(m * m);
    endfunction

    // Stage enables
    assign d_en    = !r_d_valid || i_take;
    assign a_en    = !r_a_valid || d_en;
    assign o_stall = !a_en;
    assign o_valid = r_d_valid;
    assign o_word  = r_d;

    // Distances to all four corners for both endpoints
    always_comb begin
        pts[0] = '{y: r_a.start_y, x: r_a.start_x};
        pts[1] = '{y: r_a.end_y,   x: r_a.end_x};
        n_d.last = r_a.last_segment;
        for (int p = 0; p < NUM_PTS; p++) begin
            sq_xl[p] = f_sq_diff(MAG_BITS'(pts[p].x), '0);
            sq_xr[p] = f_sq_diff(MAG_BITS'(pts[p].x), MAG_BITS'(i_width));
            sq_yt[p] = f_sq_diff(MAG_BITS'(pts[p].y), '0);
            sq_yb[p] = f_sq_diff(MAG_BITS'(pts[p].y), MAG_BITS'(i_height));
            n_d.pt[p] = pts[p];
            n_d.sq_dist[p][CORNER_TL] = DIST_BITS'(sq_xl[p]) + DIST_BITS'(sq_yt[p]);
            n_d.sq_dist[p][CORNER_TR] = DIST_BITS'(sq_xr[p]) + DIST_BITS'(sq_yt[p]);
            n_d.sq_dist[p][CORNER_BR] = DIST_BITS'(sq_xr[p]) + DIST_BITS'(sq_yb[p]);
            n_d.sq_dist[p][CORNER_BL] = DIST_BITS'(sq_xl[p]) + DIST_BITS'(sq_yb[p]);
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_valid <= i_valid;
            end
            if (d_en) begin
                r_d_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en && i_valid) begin
            r_a <= i_word;
        end
        if (d_en && r_a_valid) begin
            r_d <= n_d;
        end
    end

endmodule

// ----- design/npfc_best.sv -----
// Running best point per corner and the output register for frame results.
// Depends on npfc_pkg.
module npfc_best (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_take,
    input  npfc_pkg::t_dist_word            i_word,
    input  logic [npfc_pkg::BOUND_BITS-1:0] i_bound,
    output logic                            o_valid,
    input  logic                            i_stall,
    output npfc_pkg::t_out_word             o_word
);
    import npfc_pkg::*;

    t_dist                  r_best_dist [NUM_CORNERS];
    t_point                 r_best_pt   [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] r_found;
    logic                   r_out_valid;
    t_out_word              r_out;

    t_dist                  n_best_dist [NUM_CORNERS];
    t_point                 n_best_pt   [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] n_found;
    t_out_word              n_out;
    t_dist                  cur;
    t_point                 rep_pt [NUM_CORNERS];
    logic                   out_free;
    logic                   fire;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = i_valid && (!i_word.last || out_free);
    assign o_take   = fire;
    assign o_valid  = r_out_valid;
    assign o_word   = r_out;

    // Endpoint 0 then endpoint 1 against each corner's current best
    always_comb begin
        for (int c = 0; c < NUM_CORNERS; c++) begin
            cur            = r_found[c] ? r_best_dist[c] : DIST_BITS'(i_bound);
            n_best_dist[c] = r_best_dist[c];
            n_best_pt[c]   = r_best_pt[c];
            n_found[c]     = r_found[c];
            for (int p = 0; p < NUM_PTS; p++) begin
                if (i_word.sq_dist[p][c] < cur) begin
                    cur            = i_word.sq_dist[p][c];
                    n_best_dist[c] = i_word.sq_dist[p][c];
                    n_best_pt[c]   = i_word.pt[p];
                    n_found[c]     = 1'b1;
                end
            end
            rep_pt[c] = n_found[c] ? n_best_pt[c] : '0;
        end
    end

    // Frame summary word
    always_comb begin
        n_out.top_left_x     = rep_pt[CORNER_TL].x;
        n_out.top_left_y     = rep_pt[CORNER_TL].y;
        n_out.top_right_x    = rep_pt[CORNER_TR].x;
        n_out.top_right_y    = rep_pt[CORNER_TR].y;
        n_out.bottom_right_x = rep_pt[CORNER_BR].x;
        n_out.bottom_right_y = rep_pt[CORNER_BR].y;
        n_out.bottom_left_x  = rep_pt[CORNER_BL].x;
        n_out.bottom_left_y  = rep_pt[CORNER_BL].y;
        n_out.corners_found  = n_found;
    end

    // Control: found mask and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_found <= i_word.last ? '0 : n_found;
            end
            if (fire && i_word.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: bests and output word
    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r_best_dist[c] <= n_best_dist[c];
                r_best_pt[c]   <= n_best_pt[c];
            end
        end
        if (fire && i_word.last) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- design/npfc_checker.sv -----
// Port-level checker for nearest_point_to_frame_corners, bound to the top level.
// Depends on npfc_pkg.
module npfc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  npfc_pkg::t_in_word                 i_in_word,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  npfc_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [npfc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [npfc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import npfc_pkg::*;

    // A stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while stalled");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // Register writes only while no segment is offered, with known index and data
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !i_in_valid && !$isunknown({i_cfg_index, i_cfg_data}))
        else $error("register write with a segment offered");

    // Unfound corners report zero coordinates
    a_unfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_word.corners_found[CORNER_TL] ||
             (o_out_word.top_left_x == '0 && o_out_word.top_left_y == '0)) &&
            (o_out_word.corners_found[CORNER_TR] ||
             (o_out_word.top_right_x == '0 && o_out_word.top_right_y == '0)) &&
            (o_out_word.corners_found[CORNER_BR] ||
             (o_out_word.bottom_right_x == '0 && o_out_word.bottom_right_y == '0)) &&
            (o_out_word.corners_found[CORNER_BL] ||
             (o_out_word.bottom_left_x == '0 && o_out_word.bottom_left_y == '0)))
        else $error("unfound corner with nonzero coordinates");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind nearest_point_to_frame_corners npfc_checker u_npfc_checker (.*);
